/* rtl/ilb_pkg.sv */
`default_nettype none
package ilb_pkg;

    // payload widths
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    // wide enough for any list index or count up to the largest capacity
    localparam int AT_W    = 9;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // value returned when nothing is read
    localparam logic signed [DATA_W-1:0] RD_NONE = -32'sd1;

    typedef enum logic {
        ILB_IDLE,
        ILB_GATHER
    } state_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              shift_up;
        logic              shift_down;
        logic              capture;
        logic [AT_W-1:0]   at;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage
`default_nettype wire

/* rtl/ilb_cell.sv */
`default_nettype none
module ilb_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          aclk,
    input  wire ilb_pkg::cell_cmd_t            cmd,
    input  wire logic [ilb_pkg::DATA_W-1:0]    left_data,
    input  wire logic [ilb_pkg::DATA_W-1:0]    right_data,
    output logic      [ilb_pkg::DATA_W-1:0]    data_o,
    output logic      [ilb_pkg::DATA_W-1:0]    rd_o
);
    import ilb_pkg::*;

    localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;

    // insert opens a gap at the target, delete pulls the right neighbor in
    always_comb begin
        data_next = data_reg;
        if (cmd.shift_up) begin
            if (MY_IDX > cmd.at) begin
                data_next = left_data;
            end else if (MY_IDX == cmd.at) begin
                data_next = cmd.value;
            end
        end else if (cmd.shift_down) begin
            if (MY_IDX >= cmd.at) begin
                data_next = right_data;
            end
        end
    end

    // masked copy for the read gather, reloaded on each in-range read and held
    // until the next one, zero unless this cell is addressed
    always_comb begin
        rd_next = rd_reg;
        if (cmd.capture) begin
            rd_next = (MY_IDX == cmd.at) ? data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data_o = data_reg;
    assign rd_o   = rd_reg;

endmodule
`default_nettype wire

/* rtl/ilb_ctrl.sv */
`default_nettype none
module ilb_ctrl #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic        [ilb_pkg::KIND_W-1:0] s_kind,
    input  wire logic        [ilb_pkg::POS_W-1:0]  s_position,
    input  wire logic signed [ilb_pkg::DATA_W-1:0] s_value,
    input  wire logic        [ilb_pkg::DATA_W-1:0] read_word,
    output ilb_pkg::cell_cmd_t                     cmd,
    output logic        [ilb_pkg::AT_W-1:0]        list_count,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [ilb_pkg::DATA_W-1:0]      m_read_value,
    output logic        [ilb_pkg::STAT_W-1:0]      m_status,
    output logic        [ilb_pkg::COUNT_W-1:0]     m_count
);
    import ilb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic              rd_en_reg, rd_en_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_read_value_reg, m_read_value_next;
    logic [STAT_W-1:0]        m_status_reg, m_status_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;

    logic            accept;
    logic [AT_W-1:0] pos_w;
    logic [AT_W-1:0] cnt_w;
    logic [AT_W-1:0] at_sel;
    logic            load_out;

    assign pos_w  = AT_W'(s_position);
    assign cnt_w  = AT_W'(count_reg);
    assign accept = s_valid && (state_reg == ILB_IDLE);

    // target position: head or tail for those inserts, else the request position
    always_comb begin
        case (s_kind)
            KIND_INS_HEAD: at_sel = '0;
            KIND_INS_TAIL: at_sel = cnt_w;
            default:       at_sel = pos_w;
        endcase
    end

    // request decode: range and full checks, cell command, new count
    always_comb begin
        cmd.shift_up   = 1'b0;
        cmd.shift_down = 1'b0;
        cmd.capture    = 1'b0;
        cmd.at         = at_sel;
        cmd.value      = s_value;
        count_next     = count_reg;
        stat_next      = stat_reg;
        rd_en_next     = rd_en_reg;
        if (accept) begin
            stat_next  = STAT_DONE;
            rd_en_next = 1'b0;
            unique case (s_kind) inside
                KIND_READ: begin
                    if (pos_w < cnt_w) begin
                        cmd.capture = 1'b1;
                        rd_en_next  = 1'b1;
                    end else begin
                        stat_next = STAT_RANGE;
                    end
                end
                KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AT: begin
                    if (at_sel > cnt_w) begin
                        stat_next = STAT_RANGE;
                    end else if (count_reg == CNT_FULL) begin
                        stat_next = STAT_FULL;
                    end else begin
                        cmd.shift_up = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                end
                KIND_DELETE: begin
                    if (pos_w < cnt_w) begin
                        cmd.shift_down = 1'b1;
                        count_next     = count_reg - CNT_W'(1);
                    end else begin
                        stat_next = STAT_RANGE;
                    end
                end
                default: begin
                    stat_next = STAT_RANGE;
                end
            endcase
        end
    end

    // sequencer: accept, then gather the read word into the output register
    always_comb begin
        state_next        = state_reg;
        load_out          = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        unique case (state_reg)
            ILB_IDLE: begin
                if (accept) begin
                    state_next = ILB_GATHER;
                end
            end
            ILB_GATHER: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ILB_IDLE;
                end
            end
            default: begin
                state_next = ILB_IDLE;
            end
        endcase
        if (load_out) begin
            m_valid_next      = 1'b1;
            m_read_value_next = rd_en_reg ? read_word : RD_NONE;
            m_status_next     = stat_reg;
            m_count_next      = COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ILB_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stat_reg         <= stat_next;
        rd_en_reg        <= rd_en_next;
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
        m_count_reg      <= m_count_next;
    end

    assign s_ready      = (state_reg == ILB_IDLE);
    assign list_count   = cnt_w;
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;

endmodule
`default_nettype wire

/* rtl/indexed_list_buffer_unit.sv */
`default_nettype none
// channel  | valid / ready     | payload
// ---------+-------------------+--------------------------------------
// input    | s_valid / s_ready | s_kind, s_position, s_value
// result   | m_valid / m_ready | m_read_value, m_status, m_count
//
// The cells shift or capture on the accept edge, and the captured words are
// then ORed into the output register from the gather state.
// No new item is taken until the gather state has loaded the result.
// A result waiting in the output register does not block the next accept;
// the gather stage holds until that register frees.
// Reset clears the element count and the handshake state only.
module indexed_list_buffer_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic        [ilb_pkg::KIND_W-1:0] s_kind,
    input  wire logic        [ilb_pkg::POS_W-1:0]  s_position,
    input  wire logic signed [ilb_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [ilb_pkg::DATA_W-1:0]      m_read_value,
    output logic        [ilb_pkg::STAT_W-1:0]      m_status,
    output logic        [ilb_pkg::COUNT_W-1:0]     m_count
);
    import ilb_pkg::*;

    cell_cmd_t         cmd;
    logic [AT_W-1:0]   list_count;
    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];
    logic [DATA_W-1:0] read_word;

    // controller
    ilb_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_position   (s_position),
        .s_value      (s_value),
        .read_word    (read_word),
        .cmd          (cmd),
        .list_count   (list_count),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    // row of cells, element 0 first
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        ilb_cell #(
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data_o     (cell_data[i]),
            .rd_o       (cell_rd[i])
        );
    end

    // gather: at most one cell holds a nonzero capture
    always_comb begin
        read_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            read_word = read_word | cell_rd[k];
        end
    end

`ifndef SYNTH
    // the list never grows past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        list_count <= AT_W'(CAPACITY))
        else $error("element count above capacity");

    // an accepted item occupies the gather cycle
    a_gather: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted during gather");

    // a rejected item returns the no-data value
    a_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_DONE)) |-> (m_read_value == RD_NONE))
        else $error("failed item carries data");

    // full is reported only at capacity
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_FULL)) |-> (m_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
module tb_top;
    import ilb_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200_000;

    // kinds the block does not define
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    typedef struct {
        logic        [KIND_W-1:0] kind;
        logic        [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] value;
    } list_request_t;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic        [STAT_W-1:0] status;
        logic        [COUNT_W-1:0] count;
    } list_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic        [KIND_W-1:0]  s_kind = '0;
    logic        [POS_W-1:0]   s_position = '0;
    logic signed [DATA_W-1:0]  s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DATA_W-1:0]  m_read_value;
    logic        [STAT_W-1:0]  m_status;
    logic        [COUNT_W-1:0] m_count;

    list_request_t request_queue[$];
    list_result_t  awaited_results[$];

    // shadow copy of the list as the block should hold it
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len = 0;

    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        ready_mode = 0;
    logic [15:0] stall_lfsr = 16'hACE1;

    indexed_list_buffer_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_value(m_read_value),
        .m_status    (m_status),
        .m_count     (m_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // apply one request to the shadow list and return the result it yields
    function automatic list_result_t apply_to_list(list_request_t rq);
        list_result_t r;
        int at;
        r.read_value = RD_NONE;
        r.status     = STAT_DONE;
        case (rq.kind)
            KIND_READ: begin
                if (rq.position < list_len)
                    r.read_value = list_mem[rq.position];
                else
                    r.status = STAT_RANGE;
            end
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_AT: begin
                if (rq.kind == KIND_INS_HEAD)
                    at = 0;
                else if (rq.kind == KIND_INS_TAIL)
                    at = list_len;
                else
                    at = rq.position;
                // range check wins over the full check
                if (at > list_len) begin
                    r.status = STAT_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = rq.value;
                    list_len++;
                end
            end
            KIND_DELETE: begin
                if (rq.position < list_len) begin
                    for (int i = rq.position; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end else begin
                    r.status = STAT_RANGE;
                end
            end
            default: r.status = STAT_RANGE;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    task automatic add_request(input logic [KIND_W-1:0] k, input int p,
                               input logic [DATA_W-1:0] v);
        list_request_t rq;
        rq.kind     = k;
        rq.position = p[POS_W-1:0];
        rq.value    = v;
        request_queue.push_back(rq);
    endtask

    // random extreme or plain value
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts of items with random gaps, prediction on accept
    always @(posedge aclk) begin
        list_request_t nxt;
        list_request_t took;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                took.kind     = s_kind;
                took.position = s_position;
                took.value    = s_value;
                awaited_results.push_back(apply_to_list(took));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    nxt = request_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_kind     <= nxt.kind;
                    s_position <= nxt.position;
                    s_value    <= nxt.value;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern and run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        stall_lfsr  <= {stall_lfsr[14:0],
                        stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
        if (cycle_count % 97 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= stall_lfsr[0] | stall_lfsr[3];
            2:       m_ready <= stall_lfsr[1] & stall_lfsr[5];
            default: m_ready <= (cycle_count % 5) != 0;
        endcase
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result item with no request pending: read_value %0d status %0d count %0d",
                       m_read_value, m_status, m_count);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (m_read_value !== want.read_value) begin
                    $error("m_read_value: expected %0d, got %0d", want.read_value, m_read_value);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("m_status: expected %0d, got %0d", want.status, m_status);
                    error_count++;
                end
                if (m_count !== want.count) begin
                    $error("m_count: expected %0d, got %0d", want.count, m_count);
                    error_count++;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        list_request_t rq;
        int shadow_len;
        int seg_left;
        int grow_pct;
        int roll;

        // empty list corner cases
        add_request(KIND_READ, 0, 0);
        add_request(KIND_DELETE, 0, 0);
        add_request(KIND_INS_AT, 1, 0);
        add_request(KIND_SPARE_FIRST, 31, 32'hFFFF_FFFF);
        add_request(KIND_SPARE_LAST, 0, 0);
        // every insert flavor, value extremes
        add_request(KIND_INS_HEAD, 0, 32'h7FFF_FFFF);
        add_request(KIND_INS_TAIL, 0, 32'h8000_0000);
        add_request(KIND_INS_AT, 1, 32'h0000_0000);
        add_request(KIND_INS_AT, 3, 32'hFFFF_FFFF);
        add_request(KIND_READ, 3, 0);
        add_request(KIND_DELETE, 31, 0);
        add_request(KIND_DELETE, 1, 0);
        // fill up to capacity
        repeat (13) add_request(KIND_INS_TAIL, 0, $urandom);
        // full list: range check first, then full
        add_request(KIND_INS_HEAD, 0, 32'h1234_5678);
        add_request(KIND_INS_AT, 31, 0);
        add_request(KIND_INS_AT, 16, 0);
        add_request(KIND_READ, 15, 0);
        add_request(KIND_READ, 16, 0);
        add_request(KIND_DELETE, 0, 0);
        shadow_len = 15;

        // random phases that grow, drain or churn the list
        seg_left = 0;
        grow_pct = 50;
        repeat (RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       grow_pct = 25;
                    1:       grow_pct = 50;
                    default: grow_pct = 80;
                endcase
            end
            seg_left--;
            rq.value = pick_value();
            roll     = $urandom_range(0, 99);
            if (roll < 7) begin
                rq.kind     = KIND_W'($urandom_range(0, 7));
                rq.position = POS_W'($urandom_range(0, 31));
            end else if (roll < 30) begin
                rq.kind     = KIND_READ;
                rq.position = (shadow_len > 0) ? POS_W'($urandom_range(0, shadow_len - 1))
                                               : POS_W'(0);
            end else if ($urandom_range(0, 99) < grow_pct) begin
                rq.kind     = KIND_W'($urandom_range(KIND_INS_HEAD, KIND_INS_AT));
                rq.position = POS_W'($urandom_range(0, shadow_len));
            end else begin
                rq.kind     = KIND_DELETE;
                rq.position = (shadow_len > 0) ? POS_W'($urandom_range(0, shadow_len - 1))
                                               : POS_W'(0);
            end
            case (rq.kind)
                KIND_INS_HEAD, KIND_INS_TAIL: begin
                    if (shadow_len < CAPACITY) shadow_len++;
                end
                KIND_INS_AT: begin
                    if (rq.position <= shadow_len && shadow_len < CAPACITY) shadow_len++;
                end
                KIND_DELETE: begin
                    if (rq.position < shadow_len) shadow_len--;
                end
                default: ;
            endcase
            request_queue.push_back(rq);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
